[rtl/sbe_pkg.sv]
// Package for the stack bytecode executor: opcodes, fault codes, word layout.
// No dependencies.
`timescale 1ns / 1ps
package sbe_pkg;
    localparam int STACK_DEPTH_DEF  = 256;
    localparam int HEAP_CELLS_DEF   = 4096;
    localparam int PROGRAM_SIZE_DEF = 65536;
    localparam int WORD_W = 33;

    localparam logic [7:0] OP_HALT = 8'h00, OP_JUMP = 8'h01, OP_JNZ = 8'h02,
        OP_DUP = 8'h03, OP_SWAP = 8'h04, OP_DROP = 8'h05, OP_PUSH4 = 8'h06,
        OP_PUSH2 = 8'h07, OP_PUSH1 = 8'h08, OP_ADD = 8'h09, OP_SUB = 8'h0a,
        OP_MUL = 8'h0b, OP_DIV = 8'h0c, OP_MOD = 8'h0d, OP_EQ = 8'h0e,
        OP_NE = 8'h0f, OP_LT = 8'h10, OP_GT = 8'h11, OP_LE = 8'h12,
        OP_GE = 8'h13, OP_NOT = 8'h14, OP_AND = 8'h15, OP_OR = 8'h16,
        OP_IN = 8'h17, OP_OUT = 8'h18, OP_CLOCK = 8'h2a, OP_CONS = 8'h30,
        OP_HD = 8'h31, OP_TL = 8'h32;

    localparam logic [2:0] F_NONE = 3'd0, F_UNDER = 3'd1, F_OVER = 3'd2,
        F_DIVZ = 3'd3, F_HEAP = 3'd4, F_NADDR = 3'd5, F_BADOP = 3'd6;

    // request / reply of the shared divider
    typedef struct packed {
        logic        start;
        logic        want_mod;
        logic [31:0] a;
        logic [31:0] b;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } div_rsp_t;
endpackage

[rtl/sbe_divider.sv]
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on sbe_pkg.
`timescale 1ns / 1ps
module sbe_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  sbe_pkg::div_req_t req,
    output sbe_pkg::div_rsp_t rsp
);
    logic [31:0] quo_reg, quo_next, rem_reg, rem_next, div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, na_reg, na_next, nq_reg, nq_next;
    logic        mod_reg, mod_next, done_reg, done_next;
    logic [32:0] trial;
    logic [31:0] shifted;

    always_comb begin
        quo_next = quo_reg; rem_next = rem_reg; div_next = div_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; na_next = na_reg;
        nq_next = nq_reg; mod_next = mod_reg; done_next = 1'b0;
        shifted = {rem_reg[30:0], quo_reg[31]};
        trial = {1'b0, shifted} - {1'b0, div_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            na_next   = req.a[31];
            nq_next   = req.a[31] ^ req.b[31];
            mod_next  = req.want_mod;
            quo_next  = req.a[31] ? 32'd0 - req.a : req.a;
            div_next  = req.b[31] ? 32'd0 - req.b : req.b;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (rem_reg[31] || !trial[32]) begin
                rem_next = rem_reg[31] ? shifted - div_reg : trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next; rem_reg <= rem_next; div_reg <= div_next;
        cnt_reg <= cnt_next; na_reg <= na_next; nq_reg <= nq_next;
        mod_reg <= mod_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = mod_reg ? (na_reg ? 32'd0 - rem_reg : rem_reg)
                                : (nq_reg ? 32'd0 - quo_reg : quo_reg);

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("divider done without run");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != 6'd0) else $error("divider count ran out");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg) else $error("divider started while busy");
endmodule

[rtl/stack_bytecode_executor_top.sv]
// Top level of the stack bytecode executor: sequencer, stack and heap memories.
// Depends on sbe_pkg and sbe_divider.
`timescale 1ns / 1ps
//  channel | dir | tdata fields (low bit up)                    | tuser
//  s_      | in  | opcode[7:0] operand_bytes[39:8] in_char[48:40] | -
//  m_      | out | next_pc[15:0] out_valid[16] out_char[24:17]    | -
//                  halted[25] fault[28:26]
// After the item is accepted the result is built in order by two stack reads,
// execute and write-back. Swap, hd and tl add S_HEAP for the second memory
// access; div and mod wait in S_DIV for the one-bit-per-cycle divider and its
// done flag. Reset clears pc, stack depth and heap fill; memories are not
// cleared. Input stays not ready until the result is taken.
module stack_bytecode_executor_top #(
    parameter int STACK_DEPTH  = sbe_pkg::STACK_DEPTH_DEF,
    parameter int HEAP_CELLS   = sbe_pkg::HEAP_CELLS_DEF,
    parameter int PROGRAM_SIZE = sbe_pkg::PROGRAM_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // opcode, operand_bytes, in_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // next_pc, out_valid, out_char, halted, fault
);
    localparam int SA = $clog2(STACK_DEPTH);
    localparam int HA = $clog2(HEAP_CELLS);
    localparam int PA = $clog2(PROGRAM_SIZE);
    localparam int WW = sbe_pkg::WORD_W;

    typedef enum logic [2:0] {
        S_IDLE, S_RD1, S_RD2, S_EXEC, S_HEAP, S_DIV, S_WB2, S_DONE
    } state_t;

    state_t state_reg;
    logic [7:0]  op_reg;
    logic [31:0] ob_reg;
    logic [8:0]  ic_reg;
    logic [PA-1:0] pc_reg;
    logic [SA:0]   depth_reg;
    logic [HA:0]   fill_reg;
    logic [WW-1:0] a_reg, b_reg;      // a: lower operand, b: top
    logic [WW-1:0] stack_mem [STACK_DEPTH];
    logic [WW-1:0] head_mem  [HEAP_CELLS];
    logic [WW-1:0] tail_mem  [HEAP_CELLS];
    logic [WW-1:0] srd_reg, hrd_reg;
    logic [SA-1:0] sraddr;
    logic          swe;
    logic [SA-1:0] swaddr;
    logic [WW-1:0] swdata;
    logic          out_full_reg;
    logic [31:0]   out_reg;

    sbe_pkg::div_req_t dreq;
    sbe_pkg::div_rsp_t drsp;
    sbe_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    logic [7:0]  nidx;
    logic [SA:0] dm1, dm2, dmn;
    assign nidx = ob_reg[7:0];
    assign dm1 = depth_reg - (SA+1)'(1);
    assign dm2 = depth_reg - (SA+1)'(2);
    assign dmn = depth_reg - (SA+1)'(1) - (SA+1)'(nidx);

    function automatic logic truth(input logic [32:0] w);
        return w[32] || (w[31:0] != 32'd0);
    endfunction

    // decode: operand count and fault checks
    logic binary, is_div, big_n;
    logic [2:0] fault_c;
    logic [2:0] len_c;
    logic [31:0] av, bv;
    logic        lt_ab, lt_ba;
    assign av = a_reg[31:0];
    assign bv = b_reg[31:0];
    assign lt_ab = (av ^ 32'h80000000) < (bv ^ 32'h80000000);
    assign lt_ba = (bv ^ 32'h80000000) < (av ^ 32'h80000000);
    assign big_n = {{(SA+1){1'b0}}, nidx} >= {8'd0, depth_reg};
    assign is_div = op_reg == sbe_pkg::OP_DIV || op_reg == sbe_pkg::OP_MOD;

    always_comb begin
        binary = 1'b0; fault_c = sbe_pkg::F_NONE; len_c = 3'd1;
        unique case (op_reg)
            sbe_pkg::OP_HALT: len_c = 3'd0;
            sbe_pkg::OP_JUMP: len_c = 3'd3;
            sbe_pkg::OP_JNZ: begin
                len_c = 3'd3;
                if (depth_reg == '0) fault_c = sbe_pkg::F_UNDER;
            end
            sbe_pkg::OP_DUP: begin
                len_c = 3'd2;
                if (big_n) fault_c = sbe_pkg::F_UNDER;
                else if (depth_reg >= (SA+1)'(STACK_DEPTH)) fault_c = sbe_pkg::F_OVER;
            end
            sbe_pkg::OP_SWAP: begin
                len_c = 3'd2;
                if (big_n) fault_c = sbe_pkg::F_UNDER;
            end
            sbe_pkg::OP_PUSH4, sbe_pkg::OP_PUSH2, sbe_pkg::OP_PUSH1, sbe_pkg::OP_IN: begin
                len_c = op_reg == sbe_pkg::OP_PUSH4 ? 3'd5 :
                        op_reg == sbe_pkg::OP_PUSH2 ? 3'd3 :
                        op_reg == sbe_pkg::OP_PUSH1 ? 3'd2 : 3'd1;
                if (depth_reg >= (SA+1)'(STACK_DEPTH)) fault_c = sbe_pkg::F_OVER;
            end
            sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL, sbe_pkg::OP_DIV,
            sbe_pkg::OP_MOD, sbe_pkg::OP_EQ, sbe_pkg::OP_NE, sbe_pkg::OP_LT,
            sbe_pkg::OP_GT, sbe_pkg::OP_LE, sbe_pkg::OP_GE, sbe_pkg::OP_AND,
            sbe_pkg::OP_OR, sbe_pkg::OP_CONS: begin
                binary = 1'b1;
                if (depth_reg < (SA+1)'(2)) fault_c = sbe_pkg::F_UNDER;
            end
            sbe_pkg::OP_DROP, sbe_pkg::OP_NOT, sbe_pkg::OP_OUT,
            sbe_pkg::OP_HD, sbe_pkg::OP_TL: begin
                if (depth_reg == '0) fault_c = sbe_pkg::F_UNDER;
            end
            sbe_pkg::OP_CLOCK: ;
            default: fault_c = sbe_pkg::F_BADOP;
        endcase
    end

    // checks that need the operands (valid in S_EXEC)
    logic [2:0] fault_x;
    always_comb begin
        fault_x = fault_c;
        if (fault_c == sbe_pkg::F_NONE) begin
            if (is_div && bv == 32'd0) fault_x = sbe_pkg::F_DIVZ;
            else if (op_reg == sbe_pkg::OP_CONS && fill_reg >= (HA+1)'(HEAP_CELLS))
                fault_x = sbe_pkg::F_HEAP;
            else if ((op_reg == sbe_pkg::OP_HD || op_reg == sbe_pkg::OP_TL) &&
                     (!b_reg[32] || {1'b0, bv} >= 33'(fill_reg)))
                fault_x = sbe_pkg::F_NADDR;
        end
    end

    logic [31:0] alu;
    always_comb begin
        unique case (op_reg)
            sbe_pkg::OP_ADD: alu = av + bv;
            sbe_pkg::OP_SUB: alu = av - bv;
            sbe_pkg::OP_MUL: alu = av * bv;
            sbe_pkg::OP_EQ:  alu = {31'd0, av == bv};
            sbe_pkg::OP_NE:  alu = {31'd0, av != bv};
            sbe_pkg::OP_LT:  alu = {31'd0, lt_ab};
            sbe_pkg::OP_GT:  alu = {31'd0, lt_ba};
            sbe_pkg::OP_LE:  alu = {31'd0, !lt_ba};
            sbe_pkg::OP_GE:  alu = {31'd0, !lt_ab};
            sbe_pkg::OP_AND: alu = {31'd0, truth(a_reg) && truth(b_reg)};
            default:         alu = {31'd0, truth(a_reg) || truth(b_reg)};
        endcase
    end

    state_t        state_next;
    logic [PA-1:0] pc_next;
    logic [SA:0]   depth_next;
    logic [HA:0]   fill_next;
    logic [WW-1:0] a_next, b_next;
    logic          out_full_next;
    logic [31:0]   out_next;
    logic          hwe;
    logic [HA-1:0] haddr;
    logic [PA-1:0] target;
    assign target = PA'(ob_reg[15:0]);

    // finish: build result item; commit on no fault
    function automatic logic [31:0] pack_res(input logic [15:0] np, input logic ov,
                                             input logic [7:0] oc, input logic h,
                                             input logic [2:0] f);
        return {3'd0, f, h, oc, ov, np};
    endfunction

    always_comb begin
        state_next = state_reg; pc_next = pc_reg; depth_next = depth_reg;
        fill_next = fill_reg; a_next = a_reg; b_next = b_reg;
        out_full_next = out_full_reg && !m_tready; out_next = out_reg;
        sraddr = SA'(dm1); swe = 1'b0; swaddr = SA'(dm1); swdata = b_reg;
        hwe = 1'b0; haddr = HA'(bv); dreq = '0;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_RD1;
            S_RD1: begin
                // read top of stack
                sraddr = SA'(dm1);
                state_next = S_RD2;
            end
            S_RD2: begin
                b_next = srd_reg;
                sraddr = (binary) ? SA'(dm2) : SA'(dmn);
                state_next = S_EXEC;
            end
            S_EXEC: begin
                a_next = srd_reg;
                state_next = S_WB2;
            end
            S_WB2: begin
                // a_reg now holds lower operand / depth-n entry
                if (fault_x != sbe_pkg::F_NONE || op_reg == sbe_pkg::OP_HALT) begin
                    out_next = pack_res(16'(pc_reg), 1'b0, 8'd0, 1'b1, fault_x);
                    out_full_next = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_DONE;
                    pc_next = pc_reg + PA'(len_c);
                    unique case (op_reg)
                        sbe_pkg::OP_JUMP: pc_next = target;
                        sbe_pkg::OP_JNZ: begin
                            depth_next = dm1;
                            if (truth(b_reg)) pc_next = target;
                        end
                        sbe_pkg::OP_DUP: begin
                            swe = 1'b1; swaddr = SA'(depth_reg); swdata = a_reg;
                            depth_next = depth_reg + (SA+1)'(1);
                        end
                        sbe_pkg::OP_SWAP: begin
                            swe = 1'b1; swaddr = SA'(dm1); swdata = a_reg;
                            state_next = S_HEAP;
                        end
                        sbe_pkg::OP_DROP: depth_next = dm1;
                        sbe_pkg::OP_PUSH4, sbe_pkg::OP_PUSH2, sbe_pkg::OP_PUSH1,
                        sbe_pkg::OP_IN: begin
                            swe = 1'b1; swaddr = SA'(depth_reg);
                            swdata = op_reg == sbe_pkg::OP_PUSH4 ? {1'b0, ob_reg} :
                                op_reg == sbe_pkg::OP_PUSH2 ? {1'b0, {16{ob_reg[15]}}, ob_reg[15:0]} :
                                op_reg == sbe_pkg::OP_PUSH1 ? {1'b0, {24{ob_reg[7]}}, ob_reg[7:0]} :
                                {1'b0, {23{ic_reg[8]}}, ic_reg};
                            depth_next = depth_reg + (SA+1)'(1);
                        end
                        sbe_pkg::OP_NOT: begin
                            swe = 1'b1; swdata = {32'd0, !truth(b_reg)};
                        end
                        sbe_pkg::OP_DIV, sbe_pkg::OP_MOD: begin
                            dreq.start = 1'b1; dreq.want_mod = op_reg == sbe_pkg::OP_MOD;
                            dreq.a = av; dreq.b = bv;
                            state_next = S_DIV;
                        end
                        sbe_pkg::OP_CONS: begin
                            hwe = 1'b1; haddr = HA'(fill_reg);
                            swe = 1'b1; swaddr = SA'(dm2);
                            swdata = {1'b1, 32'(fill_reg)};
                            fill_next = fill_reg + (HA+1)'(1);
                            depth_next = dm1;
                        end
                        sbe_pkg::OP_HD, sbe_pkg::OP_TL: state_next = S_HEAP;
                        sbe_pkg::OP_CLOCK, sbe_pkg::OP_OUT: ;
                        default: begin
                            swe = 1'b1; swaddr = SA'(dm2); swdata = {1'b0, alu};
                            depth_next = dm1;
                        end
                    endcase
                    if (op_reg == sbe_pkg::OP_OUT) depth_next = dm1;
                    out_next = pack_res(16'(pc_next), op_reg == sbe_pkg::OP_OUT,
                                        op_reg == sbe_pkg::OP_OUT ? b_reg[7:0] : 8'd0,
                                        1'b0, sbe_pkg::F_NONE);
                    out_full_next = state_next == S_DONE;
                end
            end
            S_HEAP: begin
                // second write of swap, or heap read result for hd/tl
                swe = 1'b1;
                if (op_reg == sbe_pkg::OP_SWAP) begin
                    swaddr = SA'(dmn); swdata = b_reg;
                end else begin
                    swaddr = SA'(dm1); swdata = hrd_reg;
                end
                out_full_next = 1'b1;
                state_next = S_DONE;
            end
            S_DIV: if (drsp.done) begin
                swe = 1'b1; swaddr = SA'(dm2); swdata = {1'b0, drsp.result};
                depth_next = dm1;
                out_full_next = 1'b1;
                state_next = S_DONE;
            end
            default: if (!out_full_reg || m_tready) state_next = S_IDLE;
        endcase
    end

    // S_DONE waits until the result has left the output register;
    // results are loaded only in transitions that start from an empty slot.
    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_full_reg;
    assign m_tdata  = out_reg;

    // heap read issued in S_WB2, so hrd_reg holds data in S_HEAP
    always_ff @(posedge aclk) begin
        srd_reg <= stack_mem[sraddr];
        if (swe) stack_mem[swaddr] <= swdata;
        hrd_reg <= (op_reg == sbe_pkg::OP_HD) ? head_mem[haddr] : tail_mem[haddr];
        if (hwe) begin
            head_mem[haddr] <= a_reg;
            tail_mem[haddr] <= b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next; b_reg <= b_next;
        if (state_reg == S_IDLE && s_tvalid) begin
            op_reg <= s_tdata[7:0];
            ob_reg <= s_tdata[39:8];
            ic_reg <= s_tdata[48:40];
        end
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pc_reg <= '0; depth_reg <= '0; fill_reg <= '0;
            out_full_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg <= pc_next; depth_reg <= depth_next; fill_reg <= fill_next;
            out_full_reg <= out_full_next;
            if (state_reg == S_WB2 || state_reg == S_HEAP || state_reg == S_DIV)
                out_reg <= out_next;
        end
    end

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !s_tready) else $error("ready while busy");
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= (SA+1)'(STACK_DEPTH)) else $error("stack depth overrun");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= (HA+1)'(HEAP_CELLS)) else $error("heap fill overrun");
    a_fill_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg != $past(fill_reg) |-> $past(state_reg) == S_WB2)
        else $error("heap fill moved outside write-back");
endmodule
